// ===== src/ppst_pkg.sv =====
// ----------------------------------------------------------------------------
// ppst_pkg
// Shared types and constants for the parity-partitioned set table: opcodes,
// controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package ppst_pkg;

  localparam int OP_W  = 3;
  localparam int VAL_W = 31;
  localparam int POS_W = 4;
  localparam int OUT_W = 5;

  // Opcodes carried by each transaction
  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE_VAL = 3'd1,
    OP_REMOVE_POS = 3'd2,
    OP_REPLACE    = 3'd3,
    OP_SEARCH     = 3'd4
  } op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DECIDE,
    ST_SHL,
    ST_DEL_UPD,
    ST_INS_PREP,
    ST_SHR,
    ST_INS,
    ST_REPL,
    ST_RESULT
  } state_e;

  // Table walk modes: compare pass, shift toward head, shift toward tail
  typedef enum logic [1:0] {
    WALK_NONE,
    WALK_SCAN,
    WALK_SHL,
    WALK_SHR
  } walk_e;

  // Walk pointer load sources
  typedef enum logic [2:0] {
    PTR_KEEP,
    PTR_ZERO,
    PTR_IDX,
    PTR_POS,
    PTR_CNT
  } ptr_ld_e;

  typedef struct packed {
    logic    ld_op;    // capture the incoming transaction
    ptr_ld_e ptr_ld;
    walk_e   walk;
    logic    del_upd;  // drop count after a shift-left pass
    logic    ins_wr;   // write the new value into its slot
    logic    repl_wr;  // overwrite the matched entry in place
    logic    ok_set;
    logic    res_ld;   // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    op_e  opcode;
    logic up_done;     // ascending walk finished, nothing in flight
    logic dn_done;     // descending walk finished, nothing in flight
    logic pos_ok;
    logic full;
    logic hit_a;       // value found
    logic hit_b;       // new_value found
    logic ins_even;
    logic same_par;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/ppst_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppst_ctrl
// Sequencing state machine: scans the table or checks the position, then
// drives shift, insert or replace steps, then loads the output register.
// ----------------------------------------------------------------------------
module ppst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ppst_pkg::dp_sts_t sts_i,
  output ppst_pkg::dp_cmd_t cmd_o
);
  import ppst_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts_i.opcode)
          OP_INSERT, OP_REMOVE_VAL, OP_REPLACE, OP_SEARCH: state_d = ST_SCAN;
          OP_REMOVE_POS: state_d = sts_i.pos_ok ? ST_SHL : ST_RESULT;
          default: state_d = ST_RESULT;
        endcase
      end
      ST_SCAN: begin
        if (sts_i.up_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_RESULT;
        case (sts_i.opcode)
          OP_INSERT: begin
            if (!sts_i.full && !sts_i.hit_a) state_d = ST_INS_PREP;
          end
          OP_REMOVE_VAL: begin
            if (sts_i.hit_a) state_d = ST_SHL;
          end
          OP_REPLACE: begin
            if (sts_i.hit_a && !sts_i.hit_b) begin
              state_d = sts_i.same_par ? ST_REPL : ST_SHL;
            end
          end
          default: state_d = ST_RESULT;
        endcase
      end
      ST_SHL: begin
        if (sts_i.up_done) state_d = ST_DEL_UPD;
      end
      ST_DEL_UPD: begin
        state_d = (sts_i.opcode == OP_REPLACE) ? ST_INS_PREP : ST_RESULT;
      end
      ST_INS_PREP: begin
        state_d = sts_i.ins_even ? ST_SHR : ST_INS;
      end
      ST_SHR: begin
        if (sts_i.dn_done) state_d = ST_INS;
      end
      ST_INS:  state_d = ST_RESULT;
      ST_REPL: state_d = ST_RESULT;
      ST_RESULT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_op  = 1'b1;
          cmd_o.ptr_ld = PTR_ZERO;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.opcode == OP_REMOVE_POS && sts_i.pos_ok) cmd_o.ptr_ld = PTR_POS;
      end
      ST_SCAN: cmd_o.walk = WALK_SCAN;
      ST_DECIDE: begin
        case (sts_i.opcode)
          OP_REMOVE_VAL: begin
            if (sts_i.hit_a) cmd_o.ptr_ld = PTR_IDX;
          end
          OP_REPLACE: begin
            if (sts_i.hit_a && !sts_i.hit_b && !sts_i.same_par) cmd_o.ptr_ld = PTR_IDX;
          end
          OP_SEARCH: cmd_o.ok_set = sts_i.hit_a;
          default: cmd_o.ok_set = 1'b0;
        endcase
      end
      ST_SHL: cmd_o.walk = WALK_SHL;
      ST_DEL_UPD: begin
        cmd_o.del_upd = 1'b1;
        cmd_o.ok_set  = (sts_i.opcode != OP_REPLACE);
      end
      ST_INS_PREP: begin
        if (sts_i.ins_even) cmd_o.ptr_ld = PTR_CNT;
      end
      ST_SHR: cmd_o.walk = WALK_SHR;
      ST_INS: begin
        cmd_o.ins_wr = 1'b1;
        cmd_o.ok_set = 1'b1;
      end
      ST_REPL: begin
        cmd_o.repl_wr = 1'b1;
        cmd_o.ok_set  = 1'b1;
      end
      ST_RESULT: cmd_o.res_ld = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== src/ppst_dpath.sv =====
// ----------------------------------------------------------------------------
// ppst_dpath
// Table memory, walk pointer, match flags, entry counters and the output
// register. One read and one write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ppst_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ppst_pkg::dp_cmd_t          cmd_i,
  output ppst_pkg::dp_sts_t          sts_o,
  input  logic [ppst_pkg::OP_W-1:0]  opcode_i,
  input  logic [ppst_pkg::VAL_W-1:0] value_i,
  input  logic [ppst_pkg::VAL_W-1:0] new_value_i,
  input  logic [ppst_pkg::POS_W-1:0] position_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       ok_o,
  output logic signed [ppst_pkg::OUT_W-1:0] found_index_o,
  output logic [ppst_pkg::OUT_W-1:0] entries_held_o,
  output logic [ppst_pkg::OUT_W-1:0] evens_held_o
);
  import ppst_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PX_W  = CNT_W + POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Captured transaction
  op_e              opc_q;
  logic [VAL_W-1:0] val_q, nval_q;
  logic [POS_W-1:0] pos_q;

  // Table state
  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [CNT_W-1:0] cnt_q, cnt_d, even_q, even_d;

  // Walk pipeline
  logic [CNT_W-1:0] ptr_q, ptr_d, ptr_dec;
  logic [IDX_W-1:0] del_idx_q, rd_addr, rd_addr_q;
  logic [VAL_W-1:0] rd_data_q;
  logic             rd_en, rd_vld_q, del_par_q;
  logic             ptr_lt_cnt, ptr_gt_even;

  // Match results
  logic             hit_a_q, hit_b_q, ok_q;
  logic [IDX_W-1:0] idx_a_q;

  // Write port
  logic             we;
  logic [IDX_W-1:0] wa;
  logic [VAL_W-1:0] wd, ins_val;
  logic             ins_even;

  logic [PX_W-1:0]        pos_ext, cnt_ext;
  logic [IDX_W+OUT_W-1:0] idx_ext;
  logic [CNT_W+OUT_W-1:0] cnt_out, even_out;
  logic                   out_valid_q;

  assign pos_ext     = {{CNT_W{1'b0}}, pos_q};
  assign cnt_ext     = {{POS_W{1'b0}}, cnt_q};
  assign ptr_lt_cnt  = (ptr_q < cnt_q);
  assign ptr_gt_even = (ptr_q > even_q);
  assign ptr_dec     = ptr_q - CNT_W'(1);
  assign ins_val     = (opc_q == OP_REPLACE) ? nval_q : val_q;
  assign ins_even    = ~ins_val[0];

  // Read address and walk pointer
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q[IDX_W-1:0];
    case (cmd_i.walk)
      WALK_SCAN, WALK_SHL: rd_en = ptr_lt_cnt;
      WALK_SHR: begin
        rd_en   = ptr_gt_even;
        rd_addr = ptr_dec[IDX_W-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_ld)
      PTR_ZERO: ptr_d = '0;
      PTR_IDX:  ptr_d = CNT_W'(idx_a_q);
      PTR_POS:  ptr_d = pos_ext[CNT_W-1:0];
      PTR_CNT:  ptr_d = cnt_q;
      default: begin
        if (rd_en) ptr_d = (cmd_i.walk == WALK_SHR) ? ptr_dec : ptr_q + CNT_W'(1);
      end
    endcase
  end

  // Write port select; the controller keeps the sources exclusive
  always_comb begin
    we = 1'b0;
    wa = rd_addr_q;
    wd = rd_data_q;
    if (rd_vld_q && cmd_i.walk == WALK_SHL && rd_addr_q != del_idx_q) begin
      we = 1'b1;
      wa = rd_addr_q - IDX_W'(1);
    end else if (rd_vld_q && cmd_i.walk == WALK_SHR) begin
      we = 1'b1;
      wa = rd_addr_q + IDX_W'(1);
    end else if (cmd_i.ins_wr) begin
      we = 1'b1;
      wa = ins_even ? even_q[IDX_W-1:0] : cnt_q[IDX_W-1:0];
      wd = ins_val;
    end else if (cmd_i.repl_wr) begin
      we = 1'b1;
      wa = idx_a_q;
      wd = nval_q;
    end
  end

  // Table memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_data_q <= mem_q[rd_addr];
  end

  // Counter updates
  always_comb begin
    cnt_d  = cnt_q;
    even_d = even_q;
    if (cmd_i.del_upd) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (!del_par_q) even_d = even_q - CNT_W'(1);
    end else if (cmd_i.ins_wr) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (ins_even) even_d = even_q + CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      even_q      <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_a_q     <= 1'b0;
      hit_b_q     <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      even_q   <= even_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_en;
      if (cmd_i.ld_op) begin
        hit_a_q <= 1'b0;
        hit_b_q <= 1'b0;
        ok_q    <= 1'b0;
      end else begin
        if (cmd_i.ok_set) ok_q <= 1'b1;
        if (rd_vld_q && cmd_i.walk == WALK_SCAN) begin
          if (rd_data_q == val_q)  hit_a_q <= 1'b1;
          if (rd_data_q == nval_q) hit_b_q <= 1'b1;
        end
      end
      if (cmd_i.res_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_op) begin
      opc_q  <= op_e'(opcode_i);
      val_q  <= value_i;
      nval_q <= new_value_i;
      pos_q  <= position_i;
    end
    rd_addr_q <= rd_addr;
    if (rd_vld_q && cmd_i.walk == WALK_SCAN && rd_data_q == val_q && !hit_a_q) begin
      idx_a_q <= rd_addr_q;
    end
    if (cmd_i.ptr_ld == PTR_IDX) del_idx_q <= idx_a_q;
    if (cmd_i.ptr_ld == PTR_POS) del_idx_q <= pos_ext[IDX_W-1:0];
    // First read of a shift-left pass is the entry being dropped
    if (rd_vld_q && cmd_i.walk == WALK_SHL && rd_addr_q == del_idx_q) begin
      del_par_q <= rd_data_q[0];
    end
  end

  // Output register
  assign idx_ext  = {{OUT_W{1'b0}}, idx_a_q};
  assign cnt_out  = {{OUT_W{1'b0}}, cnt_q};
  assign even_out = {{OUT_W{1'b0}}, even_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      ok_o           <= ok_q;
      found_index_o  <= (opc_q == OP_SEARCH && hit_a_q) ? $signed(idx_ext[OUT_W-1:0])
                                                        : {OUT_W{1'b1}};
      entries_held_o <= cnt_out[OUT_W-1:0];
      evens_held_o   <= even_out[OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller
  always_comb begin
    sts_o          = '0;
    sts_o.opcode   = opc_q;
    sts_o.up_done  = !ptr_lt_cnt && !rd_vld_q;
    sts_o.dn_done  = !ptr_gt_even && !rd_vld_q;
    sts_o.pos_ok   = (pos_ext < cnt_ext);
    sts_o.full     = (cnt_q >= CAP_CNT);
    sts_o.hit_a    = hit_a_q;
    sts_o.hit_b    = hit_b_q;
    sts_o.ins_even = ins_even;
    sts_o.same_par = (val_q[0] == nval_q[0]);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

// ===== src/parity_partitioned_set_table.sv =====
// ----------------------------------------------------------------------------
// parity_partitioned_set_table
// Set of unique 31-bit values, evens at the front and odds at the back,
// with insert, remove by value, remove at position, replace and search.
// ----------------------------------------------------------------------------
// One transaction at a time. The table sits in a memory with one read and
// one write port, and every table operation walks it one entry per cycle.
// An unused opcode goes from dispatch straight to the result step. The
// input is ready again once the result is loaded into the output register.
// The next transaction is taken while the previous result waits in the
// output register. A result that is not taken holds the following
// transaction in its last step.
module parity_partitioned_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ppst_pkg::OP_W-1:0]  opcode_i,
  input  logic [ppst_pkg::VAL_W-1:0] value_i,
  input  logic [ppst_pkg::VAL_W-1:0] new_value_i,
  input  logic [ppst_pkg::POS_W-1:0] position_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic signed [ppst_pkg::OUT_W-1:0] found_index_o,
  output logic [ppst_pkg::OUT_W-1:0] entries_held_o,
  output logic [ppst_pkg::OUT_W-1:0] evens_held_o
);
  import ppst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ppst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppst_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .new_value_i    (new_value_i),
    .position_i     (position_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .ok_o           (ok_o),
    .found_index_o  (found_index_o),
    .entries_held_o (entries_held_o),
    .evens_held_o   (evens_held_o)
  );

endmodule
